/* hw/rtl/hrp_pkg.sv */
// Shared types and constants for the handshake reply parser.
// Used by hrp_char_decode, hrp_field_parse and handshake_reply_parser_unit.
// No dependencies.
package hrp_pkg;

    // Configuration limits
    localparam logic [3:0] MAX_PREFIX    = 4'd8;
    localparam logic [5:0] NUMBER_DIGITS = 6'd4;
    localparam logic [5:0] UUID_CHARS    = 6'd36;

    // Register indexes on the configuration port
    localparam logic CFG_PREFIX_BYTES  = 1'b0;
    localparam logic CFG_PREFIX_LENGTH = 1'b1;

    // Register reset values
    localparam logic [63:0] PREFIX_BYTES_RESET  = 64'h9D;
    localparam logic [3:0]  PREFIX_LENGTH_RESET = 4'd1;

    // Character codes
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_OSC    = 8'h9D;
    localparam logic [7:0] CH_ST     = 8'h9C;
    localparam logic [7:0] C1_OFFSET = 8'h40;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] UTF8_C2   = 8'hC2;
    localparam logic [7:0] UTF8_C3   = 8'hC3;

    // Dash positions inside the UUID
    localparam logic [5:0] UUID_DASH_A = 6'd8;
    localparam logic [5:0] UUID_DASH_B = 6'd13;
    localparam logic [5:0] UUID_DASH_C = 6'd18;
    localparam logic [5:0] UUID_DASH_D = 6'd23;

    typedef enum logic [2:0] {
        STATUS_ONGOING    = 3'd0,
        STATUS_SUCCESS    = 3'd1,
        STATUS_BAD_UTF8   = 3'd2,
        STATUS_BAD_ESCAPE = 3'd3,
        STATUS_BAD_PREFIX = 3'd4,
        STATUS_BAD_VERSION= 3'd5,
        STATUS_BAD_TYPE   = 3'd6,
        STATUS_BAD_UUID   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PHASE_PREFIX  = 2'd0,
        PHASE_VERSION = 2'd1,
        PHASE_TYPE    = 2'd2,
        PHASE_UUID    = 2'd3
    } phase_t;

    // UTF-8 and escape tracking
    typedef struct packed {
        logic       utf8_pending;
        logic [1:0] utf8_lead;
        logic       escape_armed;
    } char_state_t;

    // Result of decoding one raw byte
    typedef struct packed {
        logic        chr_valid;
        status_t     err;
        logic [7:0]  chr;
        char_state_t nxt;
    } char_result_t;

    // Field parsing state
    typedef struct packed {
        phase_t        phase;
        logic [5:0]    field_position;
        logic [13:0]   version_accum;
        logic [13:0]   type_accum;
        logic          digits_ok;
        logic [127:0]  uuid_shift;
    } field_state_t;

    localparam char_state_t CHAR_STATE_RESET = '{
        utf8_pending: 1'b0,
        utf8_lead:    2'b00,
        escape_armed: 1'b0
    };

    localparam field_state_t FIELD_STATE_RESET = '{
        phase:          PHASE_PREFIX,
        field_position: 6'd0,
        version_accum:  14'd0,
        type_accum:     14'd0,
        digits_ok:      1'b1,
        uuid_shift:     128'd0
    };

endpackage

/* hw/rtl/hrp_char_decode.sv */
// UTF-8 decode (code points up to 0xFF) and ESC pair folding to OSC / ST.
// Combinational; depends on hrp_pkg.
module hrp_char_decode (
    input  logic [7:0]           raw_byte,
    input  hrp_pkg::char_state_t cur,
    output hrp_pkg::char_result_t res
);
    import hrp_pkg::*;

    logic       have_code;
    logic [7:0] code;

    always_comb
    begin
        res       = '{chr_valid: 1'b0, err: STATUS_ONGOING, chr: 8'd0, nxt: cur};
        have_code = 1'b0;
        code      = raw_byte;

        // UTF-8 stage
        if (cur.utf8_pending)
        begin
            if (raw_byte[7:6] != 2'b10)
            begin
                res.err = STATUS_BAD_UTF8;
            end
            else
            begin
                code                 = {cur.utf8_lead, raw_byte[5:0]};
                have_code            = 1'b1;
                res.nxt.utf8_pending = 1'b0;
                res.nxt.utf8_lead    = 2'b00;
            end
        end
        else if (!raw_byte[7])
        begin
            have_code = 1'b1;
        end
        else if (raw_byte == UTF8_C2 || raw_byte == UTF8_C3)
        begin
            res.nxt.utf8_pending = 1'b1;
            res.nxt.utf8_lead    = raw_byte[1:0];
        end
        else
        begin
            res.err = STATUS_BAD_UTF8;
        end

        // Escape stage
        if (have_code)
        begin
            if (code == CH_ESC)
            begin
                if (cur.escape_armed)
                    res.err = STATUS_BAD_ESCAPE;
                else
                    res.nxt.escape_armed = 1'b1;
            end
            else if (cur.escape_armed)
            begin
                res.nxt.escape_armed = 1'b0;
                if (code == CH_OSC - C1_OFFSET)
                begin
                    res.chr       = CH_OSC;
                    res.chr_valid = 1'b1;
                end
                else if (code == CH_ST - C1_OFFSET)
                begin
                    res.chr       = CH_ST;
                    res.chr_valid = 1'b1;
                end
                else
                begin
                    res.err = STATUS_BAD_ESCAPE;
                end
            end
            else
            begin
                res.chr       = code;
                res.chr_valid = 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/hrp_field_parse.sv */
// Field checker: prefix, version, protocol type and dashed UUID.
// Combinational; depends on hrp_pkg.
module hrp_field_parse (
    input  logic [7:0]            chr,
    input  logic [63:0]           prefix_bytes,
    input  logic [3:0]            prefix_length,
    input  hrp_pkg::field_state_t cur,
    output hrp_pkg::field_state_t nxt,
    output hrp_pkg::status_t      result
);
    import hrp_pkg::*;

    logic [3:0]  eff_len;
    logic [5:0]  pos_inc;
    logic [7:0]  prefix_chr;
    logic        is_digit;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic        is_dash_pos;
    logic [13:0] acc_sel;
    logic [17:0] acc_wide;
    logic [13:0] acc_next;

    always_comb
    begin
        if (prefix_length == 4'd0)
            eff_len = 4'd1;
        else if (prefix_length > MAX_PREFIX)
            eff_len = MAX_PREFIX;
        else
            eff_len = prefix_length;
    end

    assign pos_inc    = cur.field_position + 6'd1;
    assign prefix_chr = prefix_bytes[{cur.field_position[2:0], 3'b000} +: 8];
    assign is_digit   = (chr >= 8'h30) && (chr <= 8'h39);

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = chr[3:0];
        if (is_digit)
            hex_val = chr[3:0];
        else if ((chr >= 8'h61 && chr <= 8'h66) || (chr >= 8'h41 && chr <= 8'h46))
            hex_val = chr[3:0] + 4'd9;
        else
            is_hex = 1'b0;
    end

    assign is_dash_pos = (cur.field_position == UUID_DASH_A) ||
                         (cur.field_position == UUID_DASH_B) ||
                         (cur.field_position == UUID_DASH_C) ||
                         (cur.field_position == UUID_DASH_D);

    // One shared times-ten-plus-digit for both number fields
    assign acc_sel  = (cur.phase == PHASE_VERSION) ? cur.version_accum : cur.type_accum;
    assign acc_wide = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + {14'd0, chr[3:0]};
    assign acc_next = acc_wide[13:0];

    always_comb
    begin
        nxt    = cur;
        result = STATUS_ONGOING;
        unique case (cur.phase)
            PHASE_PREFIX:
            begin
                if (chr != prefix_chr)
                begin
                    result = STATUS_BAD_PREFIX;
                end
                else if (pos_inc >= {2'b00, eff_len})
                begin
                    nxt.phase          = PHASE_VERSION;
                    nxt.field_position = 6'd0;
                    nxt.digits_ok      = 1'b1;
                end
                else
                begin
                    nxt.field_position = pos_inc;
                end
            end
            PHASE_VERSION, PHASE_TYPE:
            begin
                if (chr == CH_SEMI)
                begin
                    if (!cur.digits_ok ||
                        (cur.phase == PHASE_VERSION &&
                         (cur.field_position == 6'd0 || cur.version_accum == 14'd0)))
                    begin
                        result = (cur.phase == PHASE_VERSION) ? STATUS_BAD_VERSION
                                                              : STATUS_BAD_TYPE;
                    end
                    else
                    begin
                        nxt.phase          = (cur.phase == PHASE_VERSION) ? PHASE_TYPE
                                                                          : PHASE_UUID;
                        nxt.field_position = 6'd0;
                        nxt.digits_ok      = 1'b1;
                    end
                end
                else if (pos_inc > NUMBER_DIGITS)
                begin
                    result = (cur.phase == PHASE_VERSION) ? STATUS_BAD_VERSION
                                                          : STATUS_BAD_TYPE;
                end
                else
                begin
                    nxt.field_position = pos_inc;
                    if (!is_digit)
                        nxt.digits_ok = 1'b0;
                    else if (cur.digits_ok)
                    begin
                        if (cur.phase == PHASE_VERSION)
                            nxt.version_accum = acc_next;
                        else
                            nxt.type_accum = acc_next;
                    end
                end
            end
            PHASE_UUID:
            begin
                if (chr == CH_ST)
                begin
                    if (cur.field_position != UUID_CHARS || !cur.digits_ok)
                        result = STATUS_BAD_UUID;
                    else
                        result = STATUS_SUCCESS;
                end
                else if (cur.field_position >= UUID_CHARS)
                begin
                    result = STATUS_BAD_UUID;
                end
                else
                begin
                    nxt.field_position = pos_inc;
                    if (is_dash_pos)
                    begin
                        if (chr != CH_DASH)
                            nxt.digits_ok = 1'b0;
                    end
                    else if (is_hex)
                        nxt.uuid_shift = {cur.uuid_shift[123:0], hex_val};
                    else
                        nxt.digits_ok = 1'b0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

/* hw/rtl/handshake_reply_parser_unit.sv */
// Top level of the handshake reply parser: handshake, config registers, parse state.
// Depends on hrp_pkg, hrp_char_decode and hrp_field_parse.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       in_valid / in_ready        raw_byte, restart
//   out       source     out_valid / out_ready      status, client_version,
//                                                    protocol_type, uuid_high, uuid_low
//   cfg       sink       cfg_write (no wait)        cfg_index, cfg_data
//
// One byte per cycle sustained while the result side is ready. An accepted byte
// sits in the input register, is decoded and checked combinationally, and its
// status lands in the result register when the byte advances; the parse state
// updates at that same edge. A stalled result holds both stages; in_ready stays
// high while the input register is empty or moving on. Reset clears the parse
// state, loads the register defaults and empties both stages.
module handshake_reply_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [13:0] client_version,
    output logic [13:0] protocol_type,
    output logic [63:0] uuid_high,
    output logic [63:0] uuid_low,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import hrp_pkg::*;

    // Configuration registers
    logic [63:0] prefix_bytes_reg;
    logic [3:0]  prefix_length_reg;

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  raw_byte_reg;
    logic        restart_reg;

    // Parse state
    char_state_t  char_state_reg;
    char_state_t  char_state_next;
    field_state_t field_state_reg;
    field_state_t field_state_next;
    status_t      final_status_reg;
    status_t      final_status_next;

    // Result stage
    logic        out_valid_reg;
    status_t     status_reg;
    logic [13:0] client_version_reg;
    logic [13:0] protocol_type_reg;
    logic [127:0] uuid_reg;

    // State seen by this byte: a restart wipes everything first
    char_state_t  char_cur;
    field_state_t field_cur;
    status_t      status_cur;

    char_result_t dec;
    field_state_t field_parsed;
    status_t      field_status;

    logic advance;

    // Move the held byte into the result stage whenever the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign char_cur   = restart_reg ? CHAR_STATE_RESET  : char_state_reg;
    assign field_cur  = restart_reg ? FIELD_STATE_RESET : field_state_reg;
    assign status_cur = restart_reg ? STATUS_ONGOING    : final_status_reg;

    hrp_char_decode u_char_decode (
        .raw_byte (raw_byte_reg),
        .cur      (char_cur),
        .res      (dec)
    );

    hrp_field_parse u_field_parse (
        .chr           (dec.chr),
        .prefix_bytes  (prefix_bytes_reg),
        .prefix_length (prefix_length_reg),
        .cur           (field_cur),
        .nxt           (field_parsed),
        .result        (field_status)
    );

    // Hold everything once a final status is reached; otherwise advance
    // the decoder and, when a character came out, the field checker.
    always_comb
    begin
        char_state_next   = char_cur;
        field_state_next  = field_cur;
        final_status_next = status_cur;
        if (status_cur == STATUS_ONGOING)
        begin
            char_state_next = dec.nxt;
            if (dec.err != STATUS_ONGOING)
            begin
                final_status_next = dec.err;
            end
            else if (dec.chr_valid)
            begin
                field_state_next  = field_parsed;
                final_status_next = field_status;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_bytes_reg  <= PREFIX_BYTES_RESET;
            prefix_length_reg <= PREFIX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PREFIX_BYTES:  prefix_bytes_reg  <= cfg_data;
                CFG_PREFIX_LENGTH: prefix_length_reg <= cfg_data[3:0];
                default:           prefix_bytes_reg  <= prefix_bytes_reg;
            endcase
        end
    end

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_byte_reg <= raw_byte;
            restart_reg  <= restart;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_state_reg   <= CHAR_STATE_RESET;
            field_state_reg  <= FIELD_STATE_RESET;
            final_status_reg <= STATUS_ONGOING;
        end
        else if (advance)
        begin
            char_state_reg   <= char_state_next;
            field_state_reg  <= field_state_next;
            final_status_reg <= final_status_next;
        end
    end

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload: fields show only on success
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= final_status_next;
            if (final_status_next == STATUS_SUCCESS)
            begin
                client_version_reg <= field_state_next.version_accum;
                protocol_type_reg  <= field_state_next.type_accum;
                uuid_reg           <= field_state_next.uuid_shift;
            end
            else
            begin
                client_version_reg <= 14'd0;
                protocol_type_reg  <= 14'd0;
                uuid_reg           <= 128'd0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign client_version = client_version_reg;
    assign protocol_type  = protocol_type_reg;
    assign uuid_high      = uuid_reg[127:64];
    assign uuid_low       = uuid_reg[63:0];

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for handshake_reply_parser_unit: byte-level driver, result monitor,
// an in-bench parser that predicts the status of every byte. Depends on hrp_pkg and the RTL.
module testbench;
    import hrp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 9;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int MAX_PRINTED     = 40;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    // One byte transaction on the input channel
    typedef struct packed {
        logic [7:0] raw;
        logic       restart;
    } reply_byte_t;

    // One result transaction on the output channel
    typedef struct packed {
        status_t     st;
        logic [13:0] ver;
        logic [13:0] typ;
        logic [63:0] hi;
        logic [63:0] lo;
    } parse_status_t;

    // Every DUT input starts at a known value
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  raw_byte  = 8'h00;
    logic        restart   = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data  = 64'd0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic [13:0] client_version;
    logic [13:0] protocol_type;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;

    handshake_reply_parser_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_byte       (raw_byte),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .client_version (client_version),
        .protocol_type  (protocol_type),
        .uuid_high      (uuid_high),
        .uuid_low       (uuid_low),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be driven, and statuses waiting to come out
    reply_byte_t   byte_q[$];
    parse_status_t status_q[$];

    int error_count   = 0;
    int items_queued  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    logic first_of_reply = 1'b0;

    // Shadow of the configuration registers, updated only while the DUT is idle
    logic [63:0] prefix_shadow = PREFIX_BYTES_RESET;
    logic [3:0]  plen_shadow   = PREFIX_LENGTH_RESET;

    // Parser state mirrored from the specification
    logic [7:0]  p_lead;
    logic        p_cont_wait;
    logic        p_esc;
    phase_t      p_stage;
    logic [5:0]  p_pos;
    logic [13:0] p_ver;
    logic [13:0] p_typ;
    logic        p_ok;
    logic [63:0] p_hi;
    logic [63:0] p_lo;
    status_t     p_verdict;

    task automatic clear_reply_state();
        p_lead      = 8'h00;
        p_cont_wait = 1'b0;
        p_esc       = 1'b0;
        p_stage     = PHASE_PREFIX;
        p_pos       = 6'd0;
        p_ver       = 14'd0;
        p_typ       = 14'd0;
        p_ok        = 1'b1;
        p_hi        = 64'd0;
        p_lo        = 64'd0;
        p_verdict   = STATUS_ONGOING;
    endtask

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return c - CH_LOWER_A + 10;
        if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return c - CH_UPPER_A + 10;
        return -1;
    endfunction

    // Digit field step: 0 still going, 1 closed by ';', 2 too long
    function automatic int take_number_char(logic [7:0] c, logic into_type);
        if (c == CH_SEMI) return 1;
        p_pos = p_pos + 6'd1;
        if (p_pos > NUMBER_DIGITS) return 2;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (p_ok) begin
                if (into_type) p_typ = 14'(p_typ * 10 + (c - CH_ZERO));
                else p_ver = 14'(p_ver * 10 + (c - CH_ZERO));
            end
        end else begin
            p_ok = 1'b0;
        end
        return 0;
    endfunction

    // Advance the parser by one raw byte and return the status it yields
    function automatic status_t decode_byte(logic [7:0] b);
        logic [7:0] c;
        logic [5:0] p;
        int         h;
        int         eff;
        int         r;
        // UTF-8 layer: only C2/C3 leads decode to code points up to 0xFF
        if (p_cont_wait) begin
            if (b[7:6] != 2'b10) return STATUS_BAD_UTF8;
            c = {p_lead[1:0], b[5:0]};
            p_cont_wait = 1'b0;
            p_lead = 8'h00;
        end else if (b < 8'h80) begin
            c = b;
        end else if (b == UTF8_C2 || b == UTF8_C3) begin
            p_lead = b;
            p_cont_wait = 1'b1;
            return STATUS_ONGOING;
        end else begin
            return STATUS_BAD_UTF8;
        end
        // Escape layer: ESC ] maps to OSC, ESC \ maps to ST
        if (c == CH_ESC) begin
            if (p_esc) return STATUS_BAD_ESCAPE;
            p_esc = 1'b1;
            return STATUS_ONGOING;
        end
        if (p_esc) begin
            p_esc = 1'b0;
            if (c == CH_OSC - C1_OFFSET) c = CH_OSC;
            else if (c == CH_ST - C1_OFFSET) c = CH_ST;
            else return STATUS_BAD_ESCAPE;
        end
        case (p_stage)
            PHASE_PREFIX:
            begin
                if (c != prefix_shadow[8 * p_pos[2:0] +: 8]) return STATUS_BAD_PREFIX;
                p_pos = p_pos + 6'd1;
                // Clamp the length register to 1..MAX_PREFIX
                eff = plen_shadow;
                if (eff < 1) eff = 1;
                if (eff > MAX_PREFIX) eff = MAX_PREFIX;
                if (p_pos >= eff) begin
                    p_stage = PHASE_VERSION;
                    p_pos = 6'd0;
                    p_ok = 1'b1;
                end
            end
            PHASE_VERSION:
            begin
                r = take_number_char(c, 1'b0);
                if (r == 2) return STATUS_BAD_VERSION;
                if (r == 1) begin
                    if (!p_ok || p_pos == 6'd0 || p_ver == 14'd0) return STATUS_BAD_VERSION;
                    p_stage = PHASE_TYPE;
                    p_pos = 6'd0;
                    p_ok = 1'b1;
                end
            end
            PHASE_TYPE:
            begin
                r = take_number_char(c, 1'b1);
                if (r == 2) return STATUS_BAD_TYPE;
                if (r == 1) begin
                    if (!p_ok) return STATUS_BAD_TYPE;
                    p_stage = PHASE_UUID;
                    p_pos = 6'd0;
                    p_ok = 1'b1;
                end
            end
            default:
            begin
                // UUID: layout errors wait for ST, overlength fails at once
                if (c == CH_ST) begin
                    if (p_pos != UUID_CHARS || !p_ok) return STATUS_BAD_UUID;
                    return STATUS_SUCCESS;
                end
                p = p_pos;
                p_pos = p_pos + 6'd1;
                if (p_pos > UUID_CHARS) return STATUS_BAD_UUID;
                if (p == UUID_DASH_A || p == UUID_DASH_B || p == UUID_DASH_C
                        || p == UUID_DASH_D) begin
                    if (c != CH_DASH) p_ok = 1'b0;
                end else begin
                    h = hex_nibble(c);
                    if (h < 0) begin
                        p_ok = 1'b0;
                    end else begin
                        p_hi = {p_hi[59:0], p_lo[63:60]};
                        p_lo = {p_lo[59:0], h[3:0]};
                    end
                end
            end
        endcase
        return STATUS_ONGOING;
    endfunction

    // Compute the status of one accepted byte and queue it
    task automatic predict_status(reply_byte_t it);
        parse_status_t res;
        if (it.restart) clear_reply_state();
        // Hold a final verdict until restart
        if (p_verdict == STATUS_ONGOING) p_verdict = decode_byte(it.raw);
        res = '0;
        res.st = p_verdict;
        if (p_verdict == STATUS_SUCCESS) begin
            res.ver = p_ver;
            res.typ = p_typ;
            res.hi  = p_hi;
            res.lo  = p_lo;
        end
        status_q.push_back(res);
    endtask

    task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    // Driver: present the next byte only when the channel is free or just accepted
    always @(posedge clk)
    begin : byte_driver
        reply_byte_t nxt;
        if (rst_n) begin
            if (in_valid && in_ready)
                predict_status('{raw: raw_byte, restart: restart});
            if (!in_valid || in_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_q.pop_front();
                    in_valid <= 1'b1;
                    raw_byte <= nxt.raw;
                    restart  <= nxt.restart;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result transaction against the oldest prediction
    always @(posedge clk)
    begin : status_monitor
        parse_status_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (status_q.size() == 0) begin
                    report_error("unexpected result, status", status, 0);
                end else begin
                    want = status_q.pop_front();
                    if (status != want.st) report_error("status", status, want.st);
                    if (client_version != want.ver)
                        report_error("client_version", client_version, want.ver);
                    if (protocol_type != want.typ)
                        report_error("protocol_type", protocol_type, want.typ);
                    if (uuid_high != want.hi) report_error("uuid_high", uuid_high, want.hi);
                    if (uuid_low != want.lo) report_error("uuid_low", uuid_low, want.lo);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count cycles with work outstanding but no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (byte_q.size() == 0 && status_q.size() == 0 && !in_valid))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic queue_raw(logic [7:0] b);
        byte_q.push_back('{raw: b, restart: first_of_reply});
        first_of_reply = 1'b0;
        items_queued++;
    endtask

    function automatic logic [7:0] hex_char(int idx);
        if (idx < 10) return 8'(CH_ZERO + idx);
        if (idx < 16) return 8'(CH_LOWER_A + idx - 10);
        return 8'(CH_UPPER_A + idx - 16);
    endfunction

    // Pick a character that sits near a field boundary of the grammar
    function automatic logic [7:0] syntax_char();
        case ($urandom_range(4))
            0: return 8'(CH_ZERO + $urandom_range(9));
            1: return hex_char($urandom_range(10, 21));
            2: return CH_SEMI;
            3: return CH_DASH;
            default: return CH_ST;
        endcase
    endfunction

    // Encode one decoded character; values of 256 and up go out as raw bytes
    task automatic emit_char(int v);
        logic [7:0] c;
        c = v[7:0];
        if (v >= 256) begin
            queue_raw(c);
        end else if ((c == CH_OSC || c == CH_ST) && $urandom_range(1) == 1) begin
            queue_raw(CH_ESC);
            queue_raw(c - C1_OFFSET);
        end else if (c < 8'h80) begin
            queue_raw(c);
        end else begin
            queue_raw(c < 8'hC0 ? UTF8_C2 : UTF8_C3);
            queue_raw({2'b10, c[5:0]});
        end
    endtask

    // Build a reply for the current prefix (its version may be all zeros), then maybe damage it once
    task automatic add_reply();
        int chars[$];
        int eff;
        int k;
        eff = plen_shadow;
        if (eff < 1) eff = 1;
        if (eff > MAX_PREFIX) eff = MAX_PREFIX;
        for (int i = 0; i < eff; i++) chars.push_back(prefix_shadow[8 * i +: 8]);
        repeat ($urandom_range(1, 4)) chars.push_back(CH_ZERO + $urandom_range(9));
        chars.push_back(CH_SEMI);
        repeat ($urandom_range(0, 4)) chars.push_back(CH_ZERO + $urandom_range(9));
        chars.push_back(CH_SEMI);
        for (int p = 0; p < UUID_CHARS; p++) begin
            if (p == UUID_DASH_A || p == UUID_DASH_B || p == UUID_DASH_C
                    || p == UUID_DASH_D)
                chars.push_back(CH_DASH);
            else
                chars.push_back(hex_char($urandom_range(21)));
        end
        chars.push_back(CH_ST);
        k = $urandom_range(chars.size() - 1);
        case ($urandom_range(9))
            5: chars[k] = $urandom_range(255);
            6: chars[k] = syntax_char();
            7: chars.delete(k);
            8: chars.insert(k, 256 + $urandom_range(128, 255));
            9: while (chars.size() > k) void'(chars.pop_back());
            default: ;
        endcase
        first_of_reply = 1'b1;
        foreach (chars[i]) emit_char(chars[i]);
        // Trailing bytes land on a held verdict
        repeat ($urandom_range(2)) queue_raw(8'($urandom_range(255)));
    endtask

    task automatic add_noise();
        repeat ($urandom_range(3, 16)) begin
            first_of_reply = ($urandom_range(7) == 0);
            queue_raw(8'($urandom_range(255)));
        end
    endtask

    // Short targeted sequences under the reset configuration (prefix is OSC alone)
    task automatic add_directed();
        first_of_reply = 1'b1; queue_raw(8'hFF); queue_raw(8'h00);
        first_of_reply = 1'b1; queue_raw(8'hC4);
        first_of_reply = 1'b1; queue_raw(8'hC0);
        first_of_reply = 1'b1; queue_raw(8'h80);
        first_of_reply = 1'b1; queue_raw(UTF8_C2); queue_raw(CH_UPPER_A);
        first_of_reply = 1'b1; queue_raw(CH_ESC); queue_raw(CH_ESC);
        first_of_reply = 1'b1; queue_raw(CH_ESC); queue_raw(CH_UPPER_A);
        // Zero version is rejected on its ';'
        first_of_reply = 1'b1; queue_raw(CH_ESC); queue_raw(CH_OSC - C1_OFFSET);
        queue_raw(CH_ZERO); queue_raw(CH_SEMI);
        // Fifth digit is rejected at once
        first_of_reply = 1'b1; queue_raw(CH_ESC); queue_raw(CH_OSC - C1_OFFSET);
        for (int d = 1; d <= 5; d++) queue_raw(8'(CH_ZERO + d));
        first_of_reply = 1'b1; queue_raw(8'h78);
    endtask

    // Write one register; idle DUT assumed
    task automatic write_reg(logic idx, logic [63:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PREFIX_BYTES) prefix_shadow = v;
        else plen_shadow = v[3:0];
    endtask

    // Hold until every byte is accepted and every status has come out, then drain
    task automatic wait_idle();
        @(negedge clk);
        while (byte_q.size() != 0 || in_valid || status_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [63:0] random_prefix();
        logic [63:0] v;
        v = {$urandom, $urandom};
        // Drop ESC from the prefix so that replies can match it
        for (int i = 0; i < 8; i++)
            if (v[8 * i +: 8] == CH_ESC) v[8 * i +: 8] = CH_ESC ^ 8'h80;
        return v;
    endfunction

    initial
    begin : stimulus
        logic [63:0] pbytes;
        logic [63:0] plen;
        int          phase_start;
        clear_reply_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // Sender pauses here until the previous phase has fully drained
            wait_idle();
            if (phase < 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 73;
            end else if (phase < 6) begin
                send_idle_pct = 73;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase != 0) begin
                plen = {$urandom, $urandom};
                case (phase)
                    1: begin pbytes = '1; plen[3:0] = 4'd8; end
                    2: begin pbytes = '0; plen[3:0] = 4'd0; end
                    3: begin pbytes = random_prefix(); plen[3:0] = 4'd15; end
                    4: begin pbytes = 64'h9C9D_9C9D_9C9D_9C9D; plen[3:0] = 4'd9; end
                    5: begin pbytes = random_prefix(); plen[3:0] = 4'd1; end
                    default:
                    begin
                        pbytes = random_prefix();
                        plen[3:0] = 4'($urandom_range(15));
                    end
                endcase
                write_reg(CFG_PREFIX_BYTES, pbytes);
                write_reg(CFG_PREFIX_LENGTH, plen);
            end
            @(negedge clk);
            if (phase == 0) add_directed();
            phase_start = items_queued;
            while (items_queued - phase_start < ITEMS_PER_PHASE) begin
                if ($urandom_range(9) < 8) add_reply();
                else add_noise();
            end
        end
        wait_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_char_decode.sv
hw/rtl/hrp_field_parse.sv
hw/rtl/handshake_reply_parser_unit.sv
verif/testbench.sv
